FILE: design/ued_pkg.sv
// ued_pkg: shared types, constants and decode helpers for the UTF-8 escape decoder.
// Used by utf8_escape_decoder; no dependencies of its own.

package ued_pkg;

  // Width of the running character counter
  localparam int COUNT_BITS = 32;

  localparam logic [7:0] BACKSLASH   = 8'h5C;
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] ESC_HEX_CHR = 8'h78;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] TAG_MASK    = 8'hC0;
  localparam logic [7:0] CONT_BITS   = 8'h3F;

  // Escape classes
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_SIMPLE = 2'd1;
  localparam logic [1:0] ESC_HEX    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } esc_t;

  // One result transaction
  typedef struct packed {
    logic [23:0] code_point;
    logic        char_valid;
    logic        status;
    logic [31:0] char_count;
    logic [23:0] peak_code;
    logic        last;
  } res_t;

  // Hex digit value; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
    return v;
  endfunction

  // Classify the byte that follows a backslash
  function automatic esc_t escape_lookup(input logic [7:0] b);
    esc_t e;
    e.kind  = ESC_SIMPLE;
    e.value = 8'h00;
    case (b)
      8'h22:       e.value = 8'h22;
      8'h5C:       e.value = 8'h5C;
      8'h66:       e.value = 8'h0C;
      8'h6E:       e.value = 8'h0A;
      8'h72:       e.value = 8'h0D;
      8'h74:       e.value = 8'h09;
      8'h76:       e.value = 8'h0B;
      8'h75:       e.value = 8'h75;
      8'h30:       e.value = 8'h00;
      ESC_HEX_CHR: e.kind  = ESC_HEX;
      default:     e.kind  = ESC_NONE;
    endcase
    return e;
  endfunction

endpackage

FILE: design/utf8_escape_decoder.sv
// utf8_escape_decoder: byte-serial UTF-8 decoder with optional backslash escapes.
// Depends on ued_pkg (types, constants, hex and escape helpers).
//
// Usage:
//   Input channel (in_valid/in_ready) takes one byte per transaction, with
//   in_is_last marking the final byte of a string. Each byte gives zero, one
//   or two result transactions on the output channel (out_valid/out_ready).
//   The configuration channel (cfg_valid/cfg_ready) writes escape_enable; it
//   is always ready and is meant to be written between strings.
//   A result is written into the result queue when its byte is accepted and
//   is offered from the queue head. Throughput: one byte per cycle while
//   in_ready is high. The byte is decoded in a single combinational pass
//   against the per-string state, and its results go into a four-entry
//   result queue; in_ready holds while the queue has room for two results,
//   so a byte that yields two results costs the output side an extra transfer.
//   Reset (rst_n low, synchronous) clears the string state, escape_enable
//   and the result queue. When the receiver stalls, results wait in the
//   queue and input stops after the queue fills; nothing is dropped.

module utf8_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_escape_enable,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_input_byte,
  input  logic        in_is_last,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_code_point,
  output logic        out_char_valid,
  output logic        out_status,
  output logic [31:0] out_char_count,
  output logic [23:0] out_peak_code,
  output logic        out_last
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CONT   = 3'd1;
  localparam logic [2:0] PH_ESC    = 3'd2;
  localparam logic [2:0] PH_HEX1   = 3'd3;
  localparam logic [2:0] PH_HEX2   = 3'd4;
  localparam logic [2:0] PH_BROPEN = 3'd5;
  localparam logic [2:0] PH_BRACE  = 3'd6;
  localparam logic [2:0] PH_ERR    = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [ued_pkg::COUNT_BITS-1:0] CNT_ONE = 1;

  logic                        esc_en_r;
  logic [2:0]                  phase_r, phase_nxt;
  logic [1:0]                  left_r, left_nxt;
  logic [23:0]                 acc_r, acc_nxt;
  logic [ued_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [23:0]                 big_r, big_nxt;

  ued_pkg::res_t               res [2];
  logic [1:0]                  n_res;

  ued_pkg::res_t               queue_r [QDEPTH];
  logic [QAW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [QAW:0]                fill_r;

  logic                        in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fill_r <= (QAW+1)'(QDEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (fill_r != '0);
  assign out_acc   = out_valid && out_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      esc_en_r <= cfg_escape_enable;
    end
  end

  // Decode one byte against the string state
  always_comb begin
    logic [7:0]    b;
    logic          lst;
    logic          dlv_req, dlv_track, do_lead, cmp_req, cmp_multi;
    logic [23:0]   dlv_code, cmp_code;
    logic [4:0]    hv;
    ued_pkg::esc_t esc;

    b         = in_input_byte;
    lst       = in_is_last;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    big_nxt   = big_r;
    n_res     = 2'd0;
    res[0]    = '0;
    res[1]    = '0;
    dlv_req   = 1'b0;
    dlv_track = 1'b0;
    dlv_code  = '0;
    do_lead   = 1'b0;
    cmp_req   = 1'b0;
    cmp_multi = 1'b0;
    cmp_code  = '0;
    hv        = ued_pkg::hex_value(b);
    esc       = ued_pkg::escape_lookup(b);

    // Per-phase handling
    case (phase_r)
      PH_IDLE: begin
        do_lead = 1'b1;
      end
      PH_CONT: begin
        if ((b & ued_pkg::TAG_MASK) != ued_pkg::CONT_TAG) begin
          phase_nxt = PH_ERR;
        end else begin
          acc_nxt = {acc_r[17:0], b[5:0]};
          if (left_r != 2'd0) left_nxt = left_r - 2'd1;
          if (left_nxt == 2'd0) begin
            cmp_req   = 1'b1;
            cmp_multi = 1'b1;
            cmp_code  = acc_nxt;
          end else if (lst) begin
            phase_nxt = PH_ERR;
          end
        end
      end
      PH_ESC: begin
        case (esc.kind)
          ued_pkg::ESC_SIMPLE: begin
            dlv_req   = 1'b1;
            dlv_track = 1'b1;
            dlv_code  = 24'(esc.value);
          end
          ued_pkg::ESC_HEX: begin
            if (lst) begin
              phase_nxt = PH_ERR;
            end else begin
              acc_nxt   = '0;
              phase_nxt = PH_HEX1;
            end
          end
          default: begin
            // Unknown escape: emit the backslash, then decode this byte anew
            dlv_req  = 1'b1;
            dlv_code = 24'(ued_pkg::BACKSLASH);
            do_lead  = 1'b1;
          end
        endcase
      end
      PH_HEX1: begin
        if (lst) begin
          phase_nxt = PH_ERR;
        end else if (b == ued_pkg::OPEN_BRACE) begin
          acc_nxt   = '0;
          phase_nxt = PH_BROPEN;
        end else if (hv[4]) begin
          phase_nxt = PH_ERR;
        end else begin
          acc_nxt   = 24'(hv[3:0]);
          phase_nxt = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (hv[4]) begin
          phase_nxt = PH_ERR;
        end else begin
          dlv_req   = 1'b1;
          dlv_track = 1'b1;
          dlv_code  = {16'd0, acc_r[3:0], hv[3:0]};
        end
      end
      PH_BROPEN, PH_BRACE: begin
        if (b == ued_pkg::CLOSE_BRACE) begin
          if (phase_r == PH_BROPEN) begin
            phase_nxt = PH_ERR;
          end else begin
            dlv_req   = 1'b1;
            dlv_track = 1'b1;
            dlv_code  = acc_r;
          end
        end else if (lst || hv[4] || (acc_r[23:20] != 4'd0)) begin
          phase_nxt = PH_ERR;
        end else begin
          acc_nxt   = {acc_r[19:0], hv[3:0]};
          phase_nxt = PH_BRACE;
        end
      end
      default: begin
        // error: drop bytes until the end of the string
      end
    endcase

    // Deliver a character found by the phase logic
    if (dlv_req) begin
      if (dlv_track && dlv_code > big_nxt) big_nxt = dlv_code;
      cnt_nxt   = cnt_nxt + CNT_ONE;
      res[0]    = '{dlv_code, 1'b1, 1'b0, 32'(cnt_nxt), big_nxt, 1'b0};
      n_res     = 2'd1;
      phase_nxt = PH_IDLE;
    end

    // Lead byte
    if (do_lead) begin
      if (b < 8'h80) begin
        cmp_req  = 1'b1;
        cmp_code = 24'(b);
      end else if (b < 8'hC0 || b > 8'hF7 || lst) begin
        phase_nxt = PH_ERR;
      end else if (b < 8'hE0) begin
        acc_nxt   = 24'(b[4:0]);
        left_nxt  = 2'd1;
        phase_nxt = PH_CONT;
      end else if (b < 8'hF0) begin
        acc_nxt   = 24'(b[3:0]);
        left_nxt  = 2'd2;
        phase_nxt = PH_CONT;
      end else begin
        acc_nxt   = 24'(b[2:0]);
        left_nxt  = 2'd3;
        phase_nxt = PH_CONT;
      end
    end

    // Complete a character: open an escape or deliver it
    if (cmp_req) begin
      if (cmp_multi && cmp_code > big_nxt) big_nxt = cmp_code;
      if (esc_en_r && cmp_code == 24'(ued_pkg::BACKSLASH)) begin
        phase_nxt = lst ? PH_ERR : PH_ESC;
      end else begin
        cnt_nxt          = cnt_nxt + CNT_ONE;
        res[n_res[0]]    = '{cmp_code, 1'b1, 1'b0, 32'(cnt_nxt), big_nxt, 1'b0};
        n_res            = n_res + 2'd1;
        phase_nxt        = PH_IDLE;
      end
    end

    // End of string: close out and clear the string state
    if (lst) begin
      if (phase_nxt == PH_ERR || n_res == 2'd0) begin
        if (n_res != 2'd2) begin
          res[n_res[0]] = '{24'd0, 1'b0, 1'b1, 32'(cnt_nxt), big_nxt, 1'b1};
          n_res         = n_res + 2'd1;
        end
      end else begin
        res[n_res[0] ^ 1'b1].last = 1'b1;
      end
      phase_nxt = PH_IDLE;
      left_nxt  = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      big_nxt   = '0;
    end
  end

  // String state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      big_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      big_r   <= big_nxt;
    end
  end

  // Result queue: push up to two, pop one
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      queue_r[wr_ptr_r] <= res[0];
    end
    if (in_acc && n_res == 2'd2) begin
      queue_r[wr_ptr_r + QAW'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + QAW'(n_res);
      if (out_acc) rd_ptr_r <= rd_ptr_r + QAW'(1);
      fill_r <= fill_r + (in_acc ? (QAW+1)'(n_res) : '0) - (QAW+1)'(out_acc);
    end
  end

  // Drive the result ports from the queue head
  always_comb begin
    ued_pkg::res_t head;
    head           = queue_r[rd_ptr_r];
    out_code_point = head.code_point;
    out_char_valid = head.char_valid;
    out_status     = head.status;
    out_char_count = head.char_count;
    out_peak_code  = head.peak_code;
    out_last       = head.last;
  end

endmodule

FILE: design/ued_checker.sv
// ued_checker: port-level assertions for utf8_escape_decoder, bound to the top level.
// Sees the top-level ports only; no package dependency.

module ued_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_code_point,
  input logic        out_char_valid,
  input logic        out_status,
  input logic [31:0] out_char_count,
  input logic [23:0] out_peak_code,
  input logic        out_last
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
      $stable(out_char_count) && $stable(out_last) && $stable(out_status) &&
      $stable(out_char_valid) && $stable(out_peak_code))
    else $error("stalled result changed");

  // Drop everything on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Error results close the string and carry no character
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && !out_char_valid && out_code_point == 24'd0)
    else $error("error result not a bare final result");

  // A result without a character carries code zero and ends the string
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_last && out_code_point == 24'd0)
    else $error("empty result before end of string");

endmodule

bind utf8_escape_decoder ued_checker u_ued_checker (.*);

FILE: bench/tb.sv
// tb: self-checking bench for utf8_escape_decoder, byte stream in, code points out.
// Depends on ued_pkg for the result struct and byte constants; holds its own decoder
// model, directed strings, random well-formed and broken strings, and stall control.
`timescale 1ns / 100ps

module tb;

  // Decoder state of the prediction model
  typedef enum logic [2:0] {
    ST_IDLE, ST_CONT, ST_ESC, ST_HEX1, ST_HEX2, ST_BROPEN, ST_BRACE, ST_ERR
  } dec_state_t;

  // Escape lookup outcomes besides a plain value
  localparam int ESC_UNKNOWN = -1;
  localparam int ESC_IS_HEX  = -2;
  localparam logic [23:0] CODE_MAX = 24'hFFFFFF;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_escape_enable;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_input_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_code_point;
  logic        out_char_valid;
  logic        out_status;
  logic [31:0] out_char_count;
  logic [23:0] out_peak_code;
  logic        out_last;

  utf8_escape_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_escape_enable (cfg_escape_enable),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_input_byte     (in_input_byte),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_char_valid    (out_char_valid),
    .out_status        (out_status),
    .out_char_count    (out_char_count),
    .out_peak_code     (out_peak_code),
    .out_last          (out_last)
  );

  // Model state, one copy of everything the block keeps per string
  dec_state_t     dec_state;
  logic [1:0]     cont_left;
  logic [23:0]    code_acc;
  logic [31:0]    chars_seen;
  logic [23:0]    top_code;
  logic           esc_model;
  logic           step_last;
  int             step_n;
  ued_pkg::res_t  step_res [2];
  ued_pkg::res_t  pending_chars [$];
  ued_pkg::res_t  want;

  // Stimulus control and run statistics
  logic [7:0]  str_q [$];
  int          send_idle_pct;
  int          rcv_stall_pct;
  int          hold_left = 0;
  logic        hold_go   = 1'b0;
  logic        hold_ack  = 1'b0;
  int          bytes_sent;
  int          results_checked = 0;
  int          error_strings = 0;
  int          strings_sent;
  int          errors = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  function automatic int escape_code(logic [7:0] b);
    case (b)
      "\"":                 return 'h22;
      ued_pkg::BACKSLASH:   return 'h5C;
      "f":                  return 'h0C;
      "n":                  return 'h0A;
      "r":                  return 'h0D;
      "t":                  return 'h09;
      "v":                  return 'h0B;
      "u":                  return 'h75;
      "0":                  return 'h00;
      ued_pkg::ESC_HEX_CHR: return ESC_IS_HEX;
      default:              return ESC_UNKNOWN;
    endcase
  endfunction

  // Queue one result of the current byte; a byte never gives more than two
  function automatic void emit(logic [23:0] cp, logic valid, logic err, logic lst);
    ued_pkg::res_t r;
    if (step_n >= 2) return;
    r.code_point = cp;
    r.char_valid = valid;
    r.status     = err;
    r.char_count = chars_seen;
    r.peak_code  = top_code;
    r.last       = lst;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void fail_seq();
    dec_state = ST_ERR;
  endfunction

  function automatic void give_char(logic [23:0] code, logic track);
    if (track && code > top_code) top_code = code;
    chars_seen = chars_seen + 1;
    emit(code, 1'b1, 1'b0, 1'b0);
    dec_state = ST_IDLE;
  endfunction

  // A finished character; a backslash opens an escape when escapes are on
  function automatic void finish_code(logic [23:0] code, logic multi);
    if (multi && code > top_code) top_code = code;
    if (esc_model && code == {16'd0, ued_pkg::BACKSLASH}) begin
      if (step_last) fail_seq();
      else dec_state = ST_ESC;
      return;
    end
    give_char(code, 1'b0);
  endfunction

  function automatic void take_lead(logic [7:0] b);
    logic [7:0] lead_mask;
    int         seq_len;
    if (b < 8'h80) begin
      finish_code({16'd0, b}, 1'b0);
      return;
    end
    if (b >= 8'hC0 && b <= 8'hDF) begin
      seq_len = 2; lead_mask = 8'h1F;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_len = 3; lead_mask = 8'h0F;
    end else if (b >= 8'hF0 && b <= 8'hF7) begin
      seq_len = 4; lead_mask = 8'h07;
    end else begin
      fail_seq();
      return;
    end
    if (step_last) begin
      fail_seq();
      return;
    end
    code_acc  = {16'd0, b & lead_mask};
    cont_left = 2'(seq_len - 1);
    dec_state = ST_CONT;
  endfunction

  // Work out the results of one accepted byte and queue them
  function automatic void decode_byte(logic [7:0] b, logic lst);
    int          e;
    int          v;
    int          i;
    logic [27:0] widened;
    step_n    = 0;
    step_last = lst;
    case (dec_state)
      ST_IDLE: take_lead(b);
      ST_CONT: begin
        if ((b & ued_pkg::TAG_MASK) != ued_pkg::CONT_TAG) fail_seq();
        else begin
          code_acc = {code_acc[17:0], b[5:0]};
          if (cont_left > 2'd0) cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) finish_code(code_acc, 1'b1);
          else if (lst) fail_seq();
        end
      end
      ST_ESC: begin
        e = escape_code(b);
        if (e >= 0) give_char(24'(e), 1'b1);
        else if (e == ESC_IS_HEX) begin
          if (lst) fail_seq();
          else begin
            code_acc  = '0;
            dec_state = ST_HEX1;
          end
        end else begin
          // unknown escape: emit the backslash, then decode the byte afresh
          give_char({16'd0, ued_pkg::BACKSLASH}, 1'b0);
          take_lead(b);
        end
      end
      ST_HEX1: begin
        v = hex_digit(b);
        if (lst) fail_seq();
        else if (b == ued_pkg::OPEN_BRACE) begin
          code_acc  = '0;
          dec_state = ST_BROPEN;
        end else if (v < 0) fail_seq();
        else begin
          code_acc  = 24'(v);
          dec_state = ST_HEX2;
        end
      end
      ST_HEX2: begin
        v = hex_digit(b);
        if (v < 0) fail_seq();
        else give_char({16'd0, code_acc[3:0], 4'(v)}, 1'b1);
      end
      ST_BROPEN, ST_BRACE: begin
        v = hex_digit(b);
        if (b == ued_pkg::CLOSE_BRACE) begin
          if (dec_state == ST_BROPEN) fail_seq();
          else give_char(code_acc, 1'b1);
        end else if (lst || v < 0) fail_seq();
        else begin
          widened = {code_acc, 4'(v)};
          if (widened > {4'd0, CODE_MAX}) fail_seq();
          else begin
            code_acc  = widened[23:0];
            dec_state = ST_BRACE;
          end
        end
      end
      default: ;
    endcase
    // end of string: close it out and clear the per-string state
    if (lst) begin
      if (dec_state == ST_ERR || step_n == 0) emit('0, 1'b0, 1'b1, 1'b1);
      else step_res[step_n-1].last = 1'b1;
      dec_state  = ST_IDLE;
      cont_left  = '0;
      code_acc   = '0;
      chars_seen = '0;
      top_code   = '0;
    end
    for (i = 0; i < step_n; i++) pending_chars.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, got_v);
    end
  endfunction

  // Track config and input transactions, compare each result transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_state  = ST_IDLE;
      cont_left  = '0;
      code_acc   = '0;
      chars_seen = '0;
      top_code   = '0;
      esc_model  = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) esc_model = cfg_escape_enable;
      if (in_valid && in_ready) decode_byte(in_input_byte, in_is_last);
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got code %0h last %0b",
                   $time, out_code_point, out_last);
        end else begin
          want = pending_chars.pop_front();
          results_checked++;
          if (out_status) error_strings++;
          check_field("code_point", 32'(want.code_point), 32'(out_code_point));
          check_field("char_valid", 32'(want.char_valid), 32'(out_char_valid));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("char_count", want.char_count, out_char_count);
          check_field("peak_code", 32'(want.peak_code), 32'(out_peak_code));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when one is requested
  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack  <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one byte and hold it until the transaction completes
  task send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_input_byte <= b;
    in_is_last    <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_string;
    int i;
    for (i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  // Stop offering and wait until every expected result is back
  task wait_idle;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_chars.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task set_escape(input logic en);
    cfg_valid         <= 1'b1;
    cfg_escape_enable <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- random strings

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(v - 10);
  endfunction

  // Append a multibyte lead; returns its sequence length
  function automatic int push_lead();
    int n;
    n = $urandom_range(2, 4);
    case (n)
      2:       str_q.push_back(8'hC0 | 8'($urandom_range(31)));
      3:       str_q.push_back(8'hE0 | 8'($urandom_range(15)));
      default: str_q.push_back(8'hF0 | 8'($urandom_range(7)));
    endcase
    return n;
  endfunction

  // Build one string: mostly well-formed pieces, some noise and broken ones
  task build_string;
    int tokens;
    int t;
    int k;
    int n;
    int sel;
    logic [7:0] simple_esc [9];
    simple_esc = '{"\"", ued_pkg::BACKSLASH, "f", "n", "r", "t", "v", "u", "0"};
    str_q.delete();
    tokens = $urandom_range(1, 8);
    for (t = 0; t < tokens; t++) begin
      sel = $urandom_range(99);
      if (sel < 28) begin
        str_q.push_back(8'($urandom_range(127)));
      end else if (sel < 44) begin
        n = push_lead();
        for (k = 1; k < n; k++) str_q.push_back(ued_pkg::CONT_TAG | 8'($urandom_range(63)));
      end else if (sel < 54) begin
        str_q.push_back(ued_pkg::BACKSLASH);
        str_q.push_back(simple_esc[$urandom_range(8)]);
      end else if (sel < 62) begin
        str_q.push_back(ued_pkg::BACKSLASH);
        str_q.push_back(ued_pkg::ESC_HEX_CHR);
        str_q.push_back(hex_char($urandom_range(15)));
        str_q.push_back(hex_char($urandom_range(15)));
      end else if (sel < 71) begin
        // braced hex, sometimes pinned at the top value
        str_q.push_back(ued_pkg::BACKSLASH);
        str_q.push_back(ued_pkg::ESC_HEX_CHR);
        str_q.push_back(ued_pkg::OPEN_BRACE);
        n = $urandom_range(1, 6);
        k = $urandom_range(7);
        for (int d = 0; d < n; d++) str_q.push_back(hex_char(k == 0 ? 15 : $urandom_range(15)));
        str_q.push_back(ued_pkg::CLOSE_BRACE);
      end else if (sel < 76) begin
        str_q.push_back(ued_pkg::BACKSLASH);
        str_q.push_back(8'($urandom_range(255)));
      end else if (sel < 82) begin
        str_q.push_back(8'($urandom_range(255)));
      end else if (sel < 88) begin
        // sequence cut short, often followed by a non-continuation byte
        n = push_lead();
        k = $urandom_range(n - 2);
        for (int d = 0; d < k; d++) str_q.push_back(ued_pkg::CONT_TAG | 8'($urandom_range(63)));
        if ($urandom_range(1)) str_q.push_back(8'($urandom_range(127)));
      end else if (sel < 93) begin
        // malformed hex escape: empty braces, too many digits, or a bad digit
        str_q.push_back(ued_pkg::BACKSLASH);
        str_q.push_back(ued_pkg::ESC_HEX_CHR);
        k = $urandom_range(2);
        if (k == 0) begin
          str_q.push_back(ued_pkg::OPEN_BRACE);
          str_q.push_back(ued_pkg::CLOSE_BRACE);
        end else if (k == 1) begin
          str_q.push_back(ued_pkg::OPEN_BRACE);
          for (int d = 0; d < 7; d++) str_q.push_back(hex_char($urandom_range(15)));
          str_q.push_back(ued_pkg::CLOSE_BRACE);
        end else begin
          str_q.push_back("g");
        end
      end else begin
        str_q.push_back(8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(19) == 0) str_q.push_back(ued_pkg::BACKSLASH);
  endtask

  // ---------------------------------------------------------------- tests

  // ASCII extremes, backslash passed through, lenient multibyte forms
  task test_plain_text;
    str_q = '{8'h00, ued_pkg::BACKSLASH, 8'h7F, 8'hC0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
              8'hED, 8'hA0, 8'h80};
    send_string();
  endtask

  // Bad lead, bad continuation, truncation
  task test_malformed;
    str_q = '{8'hFF, 8'h41};
    send_string();
    str_q = '{8'hC3, 8'h41, 8'h42};
    send_string();
    str_q = '{8'hE2, 8'h82};
    send_string();
  endtask

  // Simple, hex and braced escapes, unknown escape, overlong backslash
  task test_escapes;
    str_q = '{ued_pkg::BACKSLASH, "n", ued_pkg::BACKSLASH, ued_pkg::ESC_HEX_CHR, "4", "1",
              ued_pkg::BACKSLASH, ued_pkg::ESC_HEX_CHR, ued_pkg::OPEN_BRACE,
              "F", "f", "F", "f", "F", "f", ued_pkg::CLOSE_BRACE, ued_pkg::BACKSLASH, "q",
              8'hC1, 8'h9C, "t"};
    send_string();
  endtask

  // Empty braces, value too large, bad digit, lone backslash at the end
  task test_escape_errors;
    str_q = '{ued_pkg::BACKSLASH, ued_pkg::ESC_HEX_CHR, ued_pkg::OPEN_BRACE,
              ued_pkg::CLOSE_BRACE, "A"};
    send_string();
    str_q = '{ued_pkg::BACKSLASH, ued_pkg::ESC_HEX_CHR, ued_pkg::OPEN_BRACE,
              "1", "0", "0", "0", "0", "0", "0", ued_pkg::CLOSE_BRACE};
    send_string();
    str_q = '{ued_pkg::BACKSLASH, ued_pkg::ESC_HEX_CHR, "G"};
    send_string();
    str_q = '{"A", ued_pkg::BACKSLASH};
    send_string();
    str_q = '{ued_pkg::BACKSLASH, 8'h80};
    send_string();
  endtask

  // Turn escapes off while a hex escape is open; it still runs to its end
  task test_config_mid_string;
    send_byte(ued_pkg::BACKSLASH, 1'b0);
    send_byte(ued_pkg::ESC_HEX_CHR, 1'b0);
    wait_idle();
    set_escape(1'b0);
    send_byte("4", 1'b0);
    send_byte("2", 1'b0);
    send_byte(ued_pkg::BACKSLASH, 1'b1);
    strings_sent++;
    wait_idle();
    set_escape(1'b1);
  endtask

  task test_random_traffic(input int snd_pct, input int rcv_pct, input int n_bytes,
                           input logic en);
    int target;
    wait_idle();
    set_escape(en);
    send_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_string();
      send_string();
    end
  endtask

  // Long receiver hold-off while the sender keeps streaming
  task test_backpressure;
    int target;
    wait_idle();
    send_idle_pct = 0;
    rcv_stall_pct = 10;
    hold_go      <= ~hold_go;
    target = bytes_sent + 150;
    while (bytes_sent < target) begin
      build_string();
      send_string();
    end
  endtask

  // Sender waits for all results after each string
  task test_sender_pause;
    int s;
    send_idle_pct = 20;
    rcv_stall_pct = 40;
    for (s = 0; s < 10; s++) begin
      build_string();
      send_string();
      wait_idle();
    end
  endtask

  initial begin
    int missing;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_escape_enable = 1'b0;
    in_valid          = 1'b0;
    in_input_byte     = '0;
    in_is_last        = 1'b0;
    send_idle_pct     = 20;
    rcv_stall_pct     = 20;
    bytes_sent        = 0;
    strings_sent      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_plain_text();
    test_malformed();
    wait_idle();
    set_escape(1'b1);
    test_escapes();
    test_escape_errors();
    test_config_mid_string();
    test_random_traffic(33, 58, 450, 1'b1);
    test_random_traffic(58, 33, 200, 1'b0);
    test_random_traffic(58, 33, 300, 1'b1);
    test_random_traffic(0, 0, 400, 1'b1);
    test_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (10) @(posedge clk);
    missing = pending_chars.size();
    if (missing != 0) begin
      $display("%0t: results expected %0d more, got 0", $time, missing);
    end
    $display("Sent %0d bytes in %0d strings with escapes on and off, under stalls and",
             bytes_sent, strings_sent);
    $display("a long hold-off; checked %0d results, %0d of them flagging a bad string.",
             results_checked, error_strings);
    if (errors == 0 && missing == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
design/ued_pkg.sv
design/utf8_escape_decoder.sv
design/ued_checker.sv
bench/tb.sv
